### rtl/krt_pkg.sv
package krt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int KEY_W  = 32;
	localparam int PAY_W  = 39;
	localparam int SLOT_W = 7;
	localparam int OCC_W  = 8;

	// Operation codes
	localparam logic [1:0] KIND_UPSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Status codes
	localparam logic [2:0] ST_UPDATED   = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DELETED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FOUND     = 3'd5;
	localparam logic [2:0] ST_INVALID   = 3'd6;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [7:0]  attendance;
		logic [9:0]  regular_score;
		logic [9:0]  test_score;
		logic        extra_done;
		logic [9:0]  extra_score;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] slot;
		logic [7:0] out_attendance;
		logic [9:0] out_regular_score;
		logic [9:0] out_test_score;
		logic       out_extra_done;
		logic [9:0] out_extra_score;
		logic [7:0] occupied;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_ACT   = 4'b0100,
		S_FETCH = 4'b1000
	} state_t;

endpackage

### rtl/krt_ram.sv
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/keyed_record_table_top.sv
// Keyed record table: up to TABLE_DEPTH records keyed by a nonzero 32-bit key.
// Command channel: drive cmd and raise start; the word is taken at a rising
// edge where start is high and busy is low. busy stays high until the result
// word has been produced; one command is in flight at a time.
// Result channel: done is high for exactly one cycle with the result word on
// result; the receiver cannot stall, so it must take the word in that cycle.
// Flow: a zero key or unused kind answers in the cycle after accept.
// Otherwise the key memory is scanned one slot a cycle up to the high-water
// mark; a hit stops the scan at the matching slot, and a lookup hit then
// passes through a fetch state for the payload memory read before the result
// word is registered. The single read port of the key memory sets this rate:
// the key match and the first empty slot are found in the same pass.
// Reset: asynchronous, clears count and high-water mark. Slots at or above
// the high-water mark are taken as empty, so the memories need no clearing
// pass and a command is accepted right after reset.
module keyed_record_table_top
	import krt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	state_t state_q;

	cmd_t             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] hw_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             done_q;
	result_t          result_q;

	logic             accept;
	logic             valid_cmd;
	logic             issue;
	logic             rd_hit;
	logic             scan_end;
	logic             full;
	logic [IDX_W-1:0] ins_idx;
	logic [PAY_W-1:0] cmd_pay;
	logic             key_we;
	logic [IDX_W-1:0] wr_idx;
	logic [KEY_W-1:0] key_wdata;
	logic [KEY_W-1:0] key_rdata;
	logic             pay_we;
	logic [PAY_W-1:0] pay_rdata;
	logic             done_d;
	result_t          res_d;

	assign accept    = start && !busy;
	assign valid_cmd = (cmd.key != '0) && (cmd.kind != KIND_UNUSED);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	// Scan control: issue reads below the high-water mark, compare in the next cycle
	assign issue    = (state_q == S_SCAN) && (addr_q < hw_q) && !rd_hit;
	assign rd_hit   = rd_valid_s1 && (key_rdata == cmd_q.key);
	assign scan_end = (state_q == S_SCAN) && !rd_valid_s1 && (addr_q == hw_q);

	// Insert target: first empty slot seen, else the high-water slot
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));
	assign ins_idx = free_found_q ? free_idx_q : hw_q[IDX_W-1:0];
	assign cmd_pay = {cmd_q.extra_score, cmd_q.extra_done, cmd_q.test_score,
		cmd_q.regular_score, cmd_q.attendance};

	// Memory write controls for the action step
	always_comb begin
		key_we    = 1'b0;
		pay_we    = 1'b0;
		wr_idx    = hit_q ? hit_idx_q : ins_idx;
		key_wdata = cmd_q.key;
		if (state_q == S_ACT) begin
			case (cmd_q.kind)
				KIND_UPSERT: begin
					pay_we = hit_q || !full;
					key_we = !hit_q && !full;
				end
				KIND_DELETE: begin
					key_we    = hit_q;
					key_wdata = '0;
				end
				default: begin
					key_we = 1'b0;
				end
			endcase
		end
	end

	krt_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(wr_idx),
		.wdata(key_wdata),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(key_rdata)
	);

	krt_ram #(
		.WIDTH(PAY_W),
		.DEPTH(TABLE_DEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (pay_we),
		.waddr(wr_idx),
		.wdata(cmd_pay),
		.raddr(hit_idx_q),
		.rdata(pay_rdata)
	);

	// Build the result word for the cycle that completes a command
	always_comb begin
		done_d         = 1'b0;
		res_d          = '0;
		res_d.occupied = OCC_W'(count_q);
		unique case (state_q)
			S_IDLE: begin
				if (accept && !valid_cmd) begin
					done_d       = 1'b1;
					res_d.status = ST_INVALID;
				end
			end
			S_SCAN: begin
				done_d = 1'b0;
			end
			S_ACT: begin
				done_d = 1'b1;
				case (cmd_q.kind)
					KIND_UPSERT: begin
						if (hit_q) begin
							res_d.status = ST_UPDATED;
							res_d.slot   = SLOT_W'(hit_idx_q);
						end else if (full) begin
							res_d.status = ST_FULL;
						end else begin
							res_d.status   = ST_INSERTED;
							res_d.slot     = SLOT_W'(ins_idx);
							res_d.occupied = OCC_W'(count_q + 1'b1);
						end
					end
					KIND_DELETE: begin
						if (hit_q) begin
							res_d.status   = ST_DELETED;
							res_d.slot     = SLOT_W'(hit_idx_q);
							res_d.occupied = OCC_W'(count_q - 1'b1);
						end else begin
							res_d.status = ST_NOT_FOUND;
						end
					end
					default: begin
						// Payload of a lookup hit comes back from memory next cycle
						done_d       = !hit_q;
						res_d.status = ST_NOT_FOUND;
					end
				endcase
			end
			S_FETCH: begin
				done_d                  = 1'b1;
				res_d.status            = ST_FOUND;
				res_d.slot              = SLOT_W'(hit_idx_q);
				res_d.out_attendance    = pay_rdata[7:0];
				res_d.out_regular_score = pay_rdata[17:8];
				res_d.out_test_score    = pay_rdata[27:18];
				res_d.out_extra_done    = pay_rdata[28];
				res_d.out_extra_score   = pay_rdata[38:29];
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// Capture the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// Read pipeline stage
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
	end

	// Sequencer, table counters and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			hw_q         <= '0;
			addr_q       <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q      <= done_d;
			rd_valid_s1 <= issue;
			if (done_d) begin
				result_q <= res_d;
			end
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q       <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						if (valid_cmd) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Track the first empty slot below the high-water mark
					if (rd_valid_s1 && key_rdata == '0 && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= rd_idx_s1;
					end
					if (rd_hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						state_q   <= S_ACT;
					end else if (scan_end) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (cmd_q.kind == KIND_LOOKUP && hit_q) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_IDLE;
					end
					case (cmd_q.kind)
						KIND_UPSERT: begin
							if (!hit_q && !full) begin
								count_q <= count_q + 1'b1;
								if (!free_found_q) begin
									hw_q <= hw_q + 1'b1;
								end
							end
						end
						KIND_DELETE: begin
							if (hit_q) begin
								count_q <= count_q - 1'b1;
							end
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/keyed_record_table_top_tb.sv
`timescale 1ns / 1ps

module keyed_record_table_top_tb;
	import krt_pkg::*;

	localparam int N_ITEMS   = 1850;
	localparam int POOL_SIZE = 192;
	localparam int MAX_GAP   = 12;

	// Payload held per slot
	typedef struct packed {
		logic [7:0] attendance;
		logic [9:0] regular_score;
		logic [9:0] test_score;
		logic       extra_done;
		logic [9:0] extra_score;
	} record_t;

	// Operation mix of one stretch of random traffic
	typedef enum {MIX_FILL, MIX_CHURN, MIX_EMPTY} mix_t;

	// Shadow table, expected words and result checks
	class table_scoreboard;
		logic [KEY_W-1:0] slot_keys [TABLE_DEPTH];
		record_t          slot_data [TABLE_DEPTH];
		int               high_water;
		int               entry_count;
		int               peak_count;
		result_t          expected_results [$];
		int               status_seen [8];
		int               checked;
		int               failures;

		function new();
			foreach (slot_keys[i]) slot_keys[i] = '0;
			foreach (slot_data[i]) slot_data[i] = '0;
			foreach (status_seen[i]) status_seen[i] = 0;
			high_water  = 0;
			entry_count = 0;
			peak_count  = 0;
			checked     = 0;
			failures    = 0;
		endfunction

		// Apply one command to the shadow table and return its result word
		function result_t predict_outcome(cmd_t c);
			result_t r;
			int      hit;
			int      free_slot;
			r         = '0;
			r.status  = ST_INVALID;
			hit       = -1;
			free_slot = -1;
			if (c.key != '0 && c.kind != KIND_UNUSED) begin
				// match only below the high-water mark
				for (int i = 0; i < high_water; i++) begin
					if (slot_keys[i] == c.key) begin
						hit = i;
						break;
					end
				end
				case (c.kind)
					KIND_UPSERT: begin
						if (hit >= 0) begin
							slot_data[hit] = '{c.attendance, c.regular_score, c.test_score,
								c.extra_done, c.extra_score};
							r.status = ST_UPDATED;
							r.slot   = SLOT_W'(hit);
						end else if (entry_count >= TABLE_DEPTH) begin
							r.status = ST_FULL;
						end else begin
							// fill the lowest empty slot
							for (int i = 0; i < TABLE_DEPTH; i++) begin
								if (slot_keys[i] == '0) begin
									free_slot = i;
									break;
								end
							end
							if (free_slot < 0) begin
								r.status = ST_FULL;
							end else begin
								slot_keys[free_slot] = c.key;
								slot_data[free_slot] = '{c.attendance, c.regular_score,
									c.test_score, c.extra_done, c.extra_score};
								entry_count++;
								if (free_slot + 1 > high_water)
									high_water = free_slot + 1;
								r.status = ST_INSERTED;
								r.slot   = SLOT_W'(free_slot);
							end
						end
					end
					KIND_DELETE: begin
						if (hit >= 0) begin
							slot_keys[hit] = '0;
							if (entry_count > 0)
								entry_count--;
							r.status = ST_DELETED;
							r.slot   = SLOT_W'(hit);
						end else begin
							r.status = ST_NOT_FOUND;
						end
					end
					KIND_LOOKUP: begin
						if (hit >= 0) begin
							r.status            = ST_FOUND;
							r.slot              = SLOT_W'(hit);
							r.out_attendance    = slot_data[hit].attendance;
							r.out_regular_score = slot_data[hit].regular_score;
							r.out_test_score    = slot_data[hit].test_score;
							r.out_extra_done    = slot_data[hit].extra_done;
							r.out_extra_score   = slot_data[hit].extra_score;
						end else begin
							r.status = ST_NOT_FOUND;
						end
					end
					default: ;
				endcase
			end
			r.occupied = OCC_W'(entry_count);
			if (entry_count > peak_count)
				peak_count = entry_count;
			return r;
		endfunction

		// Record an accepted command word
		function void note_command(cmd_t c);
			result_t r;
			r = predict_outcome(c);
			expected_results.push_back(r);
			status_seen[r.status]++;
		endfunction

		function string show(result_t r);
			return $sformatf(
				"status=%0d slot=%0d att=%0d reg=%0d tst=%0d xdone=%0d xsc=%0d occ=%0d",
				r.status, r.slot, r.out_attendance, r.out_regular_score, r.out_test_score,
				r.out_extra_done, r.out_extra_score, r.occupied);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("%t ERROR %s", $realtime, msg);
		endfunction

		// Compare one result word against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			string   bad;
			if (expected_results.size() == 0) begin
				flag($sformatf("result word with no command pending: %s", show(got)));
				return;
			end
			want = expected_results.pop_front();
			checked++;
			bad = "";
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.slot !== want.slot) bad = {bad, " slot"};
			if (got.out_attendance !== want.out_attendance) bad = {bad, " attendance"};
			if (got.out_regular_score !== want.out_regular_score)
				bad = {bad, " regular_score"};
			if (got.out_test_score !== want.out_test_score) bad = {bad, " test_score"};
			if (got.out_extra_done !== want.out_extra_done) bad = {bad, " extra_done"};
			if (got.out_extra_score !== want.out_extra_score) bad = {bad, " extra_score"};
			if (got.occupied !== want.occupied) bad = {bad, " occupied"};
			if (bad != "")
				flag($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
					bad, show(want), show(got)));
		endfunction
	endclass

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	table_scoreboard  sb = new();
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               n_sent     = 0;
	int               quiet_left = 0;

	keyed_record_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #4 clk = ~clk;

	// Check every result word in the cycle it is strobed
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	function automatic cmd_t make_cmd(logic [1:0] kind, logic [31:0] key, logic [7:0] att,
		logic [9:0] nrm, logic [9:0] exm, logic dn, logic [9:0] ext);
		cmd_t c;
		c = '{kind, key, att, nrm, exm, dn, ext};
		return c;
	endfunction

	// Draw a command: mostly pooled keys, some zero keys, fresh keys and unused kinds
	function automatic cmd_t random_cmd(int up_w, int del_w);
		cmd_t c;
		int   roll;
		c.attendance    = 8'($urandom);
		c.regular_score = 10'($urandom);
		c.test_score    = 10'($urandom);
		c.extra_done    = 1'($urandom);
		c.extra_score   = 10'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < up_w)
			c.kind = KIND_UPSERT;
		else if (roll < up_w + del_w)
			c.kind = KIND_DELETE;
		else
			c.kind = KIND_LOOKUP;
		if ($urandom_range(0, 99) < 3)
			c.kind = KIND_UNUSED;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			c.key = '0;
		else if (roll < 9)
			c.key = $urandom;
		else
			c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return c;
	endfunction

	// Offer one command word and wait until the block takes it
	task automatic send_cmd(input cmd_t c);
		int gap;
		if (quiet_left > 0) begin
			gap = 0;
			quiet_left--;
		end else begin
			gap = $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 49) == 0)
				quiet_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
		n_sent++;
	endtask

	// Hold off new commands until every expected word has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] k;
		int          phase_len;
		int          phase_no;
		int          up_w;
		int          del_w;
		mix_t        mix;

		foreach (key_pool[i]) begin
			do k = $urandom; while (k == '0);
			key_pool[i] = k;
		end
		key_pool[0] = 32'hFFFF_FFFF;
		key_pool[1] = 32'h0000_0001;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, zero keys, unused kind, extremes, slot reuse
		send_cmd(make_cmd(KIND_LOOKUP, 32'd5, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_DELETE, 32'd5, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UPSERT, 32'd0, 8'hFF, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF));
		send_cmd(make_cmd(KIND_DELETE, 32'd0, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_LOOKUP, 32'd0, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UNUSED, 32'h1234_5678, 8'hFF, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF));
		send_cmd(make_cmd(KIND_UNUSED, 32'd0, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UPSERT, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF));
		send_cmd(make_cmd(KIND_UPSERT, 32'd1, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UPSERT, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF));
		send_cmd(make_cmd(KIND_LOOKUP, 32'd1, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_DELETE, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UPSERT, 32'h8000_0000, 8'h80, 10'h200, 10'h155, 1'b1, 10'h2AA));
		send_cmd(make_cmd(KIND_LOOKUP, 32'h8000_0000, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_UPSERT, 32'h0000_FFFF, 8'h55, 10'h155, 10'h2AA, 1'b0, 10'h155));
		send_cmd(make_cmd(KIND_DELETE, 32'd1, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_DELETE, 32'd1, '0, '0, '0, 1'b0, '0));
		send_cmd(make_cmd(KIND_LOOKUP, 32'h0000_FFFF, '0, '0, '0, 1'b0, '0));
		hold_until_drained();

		// Random: alternate filling to capacity, churn and emptying
		phase_no = 0;
		while (n_sent < N_ITEMS) begin
			mix = mix_t'(phase_no % 3);
			case (mix)
				MIX_FILL: begin
					up_w  = 80;
					del_w = 5;
				end
				MIX_CHURN: begin
					up_w  = 40;
					del_w = 30;
				end
				default: begin
					up_w  = 15;
					del_w = 65;
				end
			endcase
			phase_len = $urandom_range(180, 280);
			if (phase_len > N_ITEMS - n_sent)
				phase_len = N_ITEMS - n_sent;
			repeat (phase_len) send_cmd(random_cmd(up_w, del_w));
			hold_until_drained();
			phase_no++;
		end

		repeat (TABLE_DEPTH + 8) @(posedge clk);
		$display("Sent %0d commands, checked %0d result words, peak occupancy %0d of %0d.",
			n_sent, sb.checked, sb.peak_count, TABLE_DEPTH);
		$display("Status mix: upd %0d ins %0d full %0d del %0d miss %0d hit %0d bad-key %0d.",
			sb.status_seen[ST_UPDATED], sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL],
			sb.status_seen[ST_DELETED], sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FOUND],
			sb.status_seen[ST_INVALID]);
		if (sb.failures == 0 && sb.expected_results.size() == 0) begin
			$display("keyed_record_table_top verification clean");
		end else begin
			$display("%0d failures, %0d words still expected",
				sb.failures, sb.expected_results.size());
			$display("keyed_record_table_top verification failed");
		end
		$finish;
	end

	// Bound the run well beyond the slowest legal completion
	initial begin
		#10_000_000;
		$display("Timeout with %0d words still expected", sb.expected_results.size());
		$display("keyed_record_table_top verification failed");
		$finish;
	end

endmodule

### keyed_record_table_top.f
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/keyed_record_table_top.sv
tb/keyed_record_table_top_tb.sv
